// ===== hw/rtl/pbd_pkg.sv =====
// Package for the predicate branch distance block.
// Predicate codes, relation classes, distance select codes and IEEE double constants.
// No dependencies.
package pbd_pkg;

    localparam int DW = 64;

    localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] NEG_ONE   = 64'hBFF0_0000_0000_0000;
    localparam logic [63:0] POS_ZERO  = 64'h0000_0000_0000_0000;

    localparam logic [1:0] CFG_EPS     = 2'd0;
    localparam logic [1:0] CFG_PENALTY = 2'd1;
    localparam logic [1:0] CFG_SELF    = 2'd2;

    localparam logic [5:0] P_FALSE = 6'd0;
    localparam logic [5:0] P_OEQ   = 6'd1;
    localparam logic [5:0] P_OGT   = 6'd2;
    localparam logic [5:0] P_OGE   = 6'd3;
    localparam logic [5:0] P_OLT   = 6'd4;
    localparam logic [5:0] P_OLE   = 6'd5;
    localparam logic [5:0] P_ONE   = 6'd6;
    localparam logic [5:0] P_ORD   = 6'd7;
    localparam logic [5:0] P_UNO   = 6'd8;
    localparam logic [5:0] P_UEQ   = 6'd9;
    localparam logic [5:0] P_UGT   = 6'd10;
    localparam logic [5:0] P_UGE   = 6'd11;
    localparam logic [5:0] P_ULT   = 6'd12;
    localparam logic [5:0] P_ULE   = 6'd13;
    localparam logic [5:0] P_UNE   = 6'd14;
    localparam logic [5:0] P_TRUE  = 6'd15;
    localparam logic [5:0] P_IEQ   = 6'd32;
    localparam logic [5:0] P_INE   = 6'd33;
    localparam logic [5:0] P_IUGT  = 6'd34;
    localparam logic [5:0] P_IUGE  = 6'd35;
    localparam logic [5:0] P_IULT  = 6'd36;
    localparam logic [5:0] P_IULE  = 6'd37;
    localparam logic [5:0] P_ISGT  = 6'd38;
    localparam logic [5:0] P_ISGE  = 6'd39;
    localparam logic [5:0] P_ISLT  = 6'd40;
    localparam logic [5:0] P_ISLE  = 6'd41;

    typedef enum logic [2:0] {
        REL_NONE, REL_EQ, REL_NE, REL_GT, REL_GE, REL_LT, REL_LE
    } t_rel;

    typedef enum logic [2:0] {
        K_ZERO, K_NEG1, K_PEN, K_EPS, K_CALC
    } t_kind;

    typedef enum logic [1:0] {
        OP_NONE, OP_ADD, OP_SUB
    } t_op2;

    typedef struct packed {
        logic  truth;
        t_kind kind;
        logic  use_abs;
        t_op2  op2;
        logic  neg;
    } t_ctl;

    function automatic t_rel rel_class(input logic [5:0] code);
        t_rel r;
        case (code)
            P_IEQ, P_OEQ, P_UEQ:           r = REL_EQ;
            P_INE, P_ONE, P_UNE:           r = REL_NE;
            P_IUGT, P_ISGT, P_OGT, P_UGT:  r = REL_GT;
            P_IUGE, P_ISGE, P_OGE, P_UGE:  r = REL_GE;
            P_IULT, P_ISLT, P_OLT, P_ULT:  r = REL_LT;
            P_IULE, P_ISLE, P_OLE, P_ULE:  r = REL_LE;
            default:                       r = REL_NONE;
        endcase
        return r;
    endfunction

    function automatic logic is_nan(input logic [63:0] b);
        return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    endfunction

    function automatic logic is_inf(input logic [63:0] b);
        return (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
    endfunction

    function automatic logic [63:0] canon(input logic [63:0] b);
        return is_nan(b) ? QNAN_BITS : b;
    endfunction

endpackage

// ===== hw/rtl/pbd_fadd.sv =====
// Three-stage IEEE double adder, round to nearest even, NaN results canonical.
// Stages: align, add and leading-zero count, normalize and round.
// Depends on pbd_pkg.
module pbd_fadd (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_sum
);

    typedef struct packed {
        logic        spec;
        logic [63:0] spec_val;
        logic        sign;
        logic        eff_sub;
        logic [11:0] exp;
        logic [55:0] m_big;
        logic [55:0] m_sml;
    } t_aln;

    typedef struct packed {
        logic        spec;
        logic [63:0] spec_val;
        logic        sign;
        logic [11:0] exp;
        logic [55:0] mant;
        logic [5:0]  shl;
    } t_nrm;

    function automatic logic [5:0] lzc56(input logic [55:0] v);
        logic [5:0] n;
        n = 6'd56;
        for (int i = 0; i < 56; i++) begin
            if (v[i]) n = 6'(55 - i);
        end
        return n;
    endfunction

    t_aln        r_aln, n_aln;
    t_nrm        r_nrm, n_nrm;
    logic [63:0] r_res, n_res;

    logic [63:0] big_v, sml_v;
    logic [10:0] eb, es, d;
    logic [55:0] sv, sh;
    logic        lost;

    always_comb begin
        n_aln = '0;
        if (i_b[62:0] > i_a[62:0]) begin
            big_v = i_b;
            sml_v = i_a;
        end else begin
            big_v = i_a;
            sml_v = i_b;
        end
        eb = (big_v[62:52] == 11'd0) ? 11'd1 : big_v[62:52];
        es = (sml_v[62:52] == 11'd0) ? 11'd1 : sml_v[62:52];
        d  = eb - es;
        sv = {sml_v[62:52] != 11'd0, sml_v[51:0], 3'b000};
        sh = sv >> d;
        lost = |(sv & ~({56{1'b1}} << d));
        n_aln.sign    = big_v[63];
        n_aln.eff_sub = i_a[63] ^ i_b[63];
        n_aln.exp     = {1'b0, eb};
        n_aln.m_big   = {big_v[62:52] != 11'd0, big_v[51:0], 3'b000};
        if (d >= 11'd56) begin
            n_aln.m_sml = {55'd0, |sv};
        end else begin
            n_aln.m_sml = {sh[55:1], sh[0] | lost};
        end
        if (pbd_pkg::is_nan(i_a) || pbd_pkg::is_nan(i_b)) begin
            n_aln.spec     = 1'b1;
            n_aln.spec_val = pbd_pkg::QNAN_BITS;
        end else if (pbd_pkg::is_inf(i_a) && pbd_pkg::is_inf(i_b)) begin
            n_aln.spec     = 1'b1;
            n_aln.spec_val = (i_a[63] != i_b[63]) ? pbd_pkg::QNAN_BITS : i_a;
        end else if (pbd_pkg::is_inf(i_a)) begin
            n_aln.spec     = 1'b1;
            n_aln.spec_val = i_a;
        end else if (pbd_pkg::is_inf(i_b)) begin
            n_aln.spec     = 1'b1;
            n_aln.spec_val = i_b;
        end
    end

    logic [56:0] s57;
    logic [5:0]  lz;
    logic [11:0] lim;

    always_comb begin
        n_nrm          = '0;
        n_nrm.spec     = r_aln.spec;
        n_nrm.spec_val = r_aln.spec_val;
        n_nrm.sign     = r_aln.sign;
        if (r_aln.eff_sub) begin
            s57 = {1'b0, r_aln.m_big} - {1'b0, r_aln.m_sml};
        end else begin
            s57 = {1'b0, r_aln.m_big} + {1'b0, r_aln.m_sml};
        end
        lz  = lzc56(s57[55:0]);
        lim = r_aln.exp - 12'd1;
        if (s57[56]) begin
            n_nrm.mant = {s57[56:2], s57[1] | s57[0]};
            n_nrm.exp  = r_aln.exp + 12'd1;
            n_nrm.shl  = 6'd0;
        end else begin
            n_nrm.mant = s57[55:0];
            n_nrm.exp  = r_aln.exp;
            n_nrm.shl  = ({6'd0, lz} > lim) ? lim[5:0] : lz;
        end
        if (s57 == 57'd0) begin
            n_nrm.sign = r_aln.eff_sub ? 1'b0 : r_aln.sign;
            n_nrm.shl  = 6'd0;
        end
    end

    logic [55:0] m;
    logic [11:0] e;
    logic [10:0] ef;
    logic [62:0] base;
    logic        up;

    always_comb begin
        m    = r_nrm.mant << r_nrm.shl;
        e    = r_nrm.exp - {6'd0, r_nrm.shl};
        ef   = m[55] ? e[10:0] : 11'd0;
        base = {ef, m[54:3]};
        up   = m[2] & (m[1] | m[0] | m[3]);
        if (r_nrm.spec) begin
            n_res = r_nrm.spec_val;
        end else if (e >= 12'd2047) begin
            n_res = {r_nrm.sign, 11'h7FF, 52'd0};
        end else begin
            n_res = {r_nrm.sign, base + {62'd0, up}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_aln <= n_aln;
            r_nrm <= n_nrm;
            r_res <= n_res;
        end
    end

    assign o_sum = r_res;

endmodule

// ===== hw/rtl/predicate_branch_distance.sv =====
// Top level of the predicate branch distance block.
// Predicate decode, two chained double adders and the result select.
// Depends on pbd_pkg and pbd_fadd.
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries two double operands, a
//   predicate code and the wanted outcome. Output channel o_out_valid /
//   i_out_ready returns the predicate truth and the double distance.
//   Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_wdata):
//   0 epsilon, 1 penalty, 2 self mode; write only while the block is idle.
//   From acceptance to o_out_valid there is one decode stage, three stages
//   for the operand difference, three for the epsilon add and one for the
//   result select. Throughput is one transaction per cycle unless stalled.
//   A stall on the output freezes the whole pipeline; nothing is lost and
//   o_in_ready drops until the output transaction completes.
//   Reset clears all valid bits and loads epsilon +0.0, penalty +0.0 and
//   self mode 1.
module predicate_branch_distance (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_left_operand,
    input  logic [63:0] i_right_operand,
    input  logic [5:0]  i_predicate_code,
    input  logic        i_wanted_outcome,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_compare_truth,
    output logic [63:0] o_distance_bits,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata
);

    logic [63:0] r_eps, r_pen;
    logic        r_self;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps  <= '0;
            r_pen  <= '0;
            r_self <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pbd_pkg::CFG_EPS:     r_eps  <= i_cfg_wdata;
                pbd_pkg::CFG_PENALTY: r_pen  <= i_cfg_wdata;
                pbd_pkg::CFG_SELF:    r_self <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic en;
    logic [7:0] r_vld;
    assign en         = ~r_vld[7] | i_out_ready;
    assign o_in_ready = en;

    // decode
    logic [63:0]   lb, rb;
    logic [5:0]    code;
    logic          want, nan, odd, bz, eq, lt, gt, raw, truth, missed, swap;
    pbd_pkg::t_rel cls;
    pbd_pkg::t_ctl n_ctl;

    always_comb begin
        lb   = i_left_operand;
        rb   = i_right_operand;
        code = i_predicate_code;
        want = i_wanted_outcome;
        nan  = pbd_pkg::is_nan(lb) || pbd_pkg::is_nan(rb);
        odd  = nan || pbd_pkg::is_inf(lb) || pbd_pkg::is_inf(rb);
        cls  = pbd_pkg::rel_class(code);
        bz   = (lb[62:0] == 63'd0) && (rb[62:0] == 63'd0);
        eq   = !nan && ((lb == rb) || bz);
        lt   = !nan && !bz && ((lb[63] != rb[63]) ? lb[63] :
               (lb[63] ? (lb[62:0] > rb[62:0]) : (lb[62:0] < rb[62:0])));
        gt   = !nan && !bz && ((lb[63] != rb[63]) ? rb[63] :
               (rb[63] ? (rb[62:0] > lb[62:0]) : (rb[62:0] < lb[62:0])));
        case (cls)
            pbd_pkg::REL_EQ: raw = eq;
            pbd_pkg::REL_NE: raw = !eq;
            pbd_pkg::REL_GT: raw = gt;
            pbd_pkg::REL_GE: raw = gt | eq;
            pbd_pkg::REL_LT: raw = lt;
            pbd_pkg::REL_LE: raw = lt | eq;
            default:         raw = 1'b0;
        endcase
        case (code)
            pbd_pkg::P_FALSE: truth = 1'b0;
            pbd_pkg::P_TRUE:  truth = 1'b1;
            pbd_pkg::P_ORD:   truth = !nan;
            pbd_pkg::P_UNO:   truth = nan;
            default: begin
                if (code inside {[pbd_pkg::P_OEQ:pbd_pkg::P_ONE]}) begin
                    truth = !nan && raw;
                end else if (code inside {[pbd_pkg::P_UEQ:pbd_pkg::P_UNE]}) begin
                    truth = nan || raw;
                end else if (code inside {[pbd_pkg::P_IEQ:pbd_pkg::P_ISLE]}) begin
                    truth = raw;
                end else begin
                    truth = 1'b0;
                end
            end
        endcase
        missed        = truth != want;
        swap          = 1'b0;
        n_ctl.truth   = truth;
        n_ctl.kind    = pbd_pkg::K_CALC;
        n_ctl.use_abs = 1'b0;
        n_ctl.op2     = pbd_pkg::OP_NONE;
        n_ctl.neg     = 1'b0;
        if (missed) begin
            if ((odd && code != pbd_pkg::P_ORD && code != pbd_pkg::P_UNO)
                    || cls == pbd_pkg::REL_NONE) begin
                if ((code == pbd_pkg::P_FALSE && !want) || (code == pbd_pkg::P_TRUE && want)) begin
                    n_ctl.kind = pbd_pkg::K_ZERO;
                end else begin
                    n_ctl.kind = pbd_pkg::K_PEN;
                end
            end else begin
                case (cls)
                    pbd_pkg::REL_EQ: begin
                        n_ctl.kind    = want ? pbd_pkg::K_CALC : pbd_pkg::K_EPS;
                        n_ctl.use_abs = 1'b1;
                    end
                    pbd_pkg::REL_NE: begin
                        n_ctl.kind    = want ? pbd_pkg::K_EPS : pbd_pkg::K_CALC;
                        n_ctl.use_abs = 1'b1;
                    end
                    pbd_pkg::REL_GT: begin
                        swap      = want;
                        n_ctl.op2 = want ? pbd_pkg::OP_ADD : pbd_pkg::OP_NONE;
                    end
                    pbd_pkg::REL_GE: begin
                        swap      = want;
                        n_ctl.op2 = want ? pbd_pkg::OP_NONE : pbd_pkg::OP_ADD;
                    end
                    pbd_pkg::REL_LT: begin
                        swap      = !want;
                        n_ctl.op2 = want ? pbd_pkg::OP_ADD : pbd_pkg::OP_NONE;
                    end
                    default: begin
                        swap      = !want;
                        n_ctl.op2 = want ? pbd_pkg::OP_NONE : pbd_pkg::OP_ADD;
                    end
                endcase
            end
        end else if (r_self) begin
            n_ctl.kind = pbd_pkg::K_ZERO;
        end else if (code == pbd_pkg::P_FALSE || code == pbd_pkg::P_TRUE
                || code == pbd_pkg::P_ORD || code == pbd_pkg::P_UNO
                || odd || cls == pbd_pkg::REL_NONE) begin
            n_ctl.kind = pbd_pkg::K_NEG1;
        end else begin
            n_ctl.neg = 1'b1;
            case (cls)
                pbd_pkg::REL_EQ: begin
                    n_ctl.kind    = want ? pbd_pkg::K_ZERO : pbd_pkg::K_CALC;
                    n_ctl.use_abs = 1'b1;
                    n_ctl.op2     = pbd_pkg::OP_SUB;
                end
                pbd_pkg::REL_NE: begin
                    n_ctl.kind    = want ? pbd_pkg::K_CALC : pbd_pkg::K_ZERO;
                    n_ctl.use_abs = 1'b1;
                    n_ctl.op2     = pbd_pkg::OP_SUB;
                end
                pbd_pkg::REL_GT: begin
                    swap      = !want;
                    n_ctl.op2 = want ? pbd_pkg::OP_SUB : pbd_pkg::OP_NONE;
                end
                pbd_pkg::REL_GE: begin
                    swap      = !want;
                    n_ctl.op2 = want ? pbd_pkg::OP_NONE : pbd_pkg::OP_SUB;
                end
                pbd_pkg::REL_LT: begin
                    swap      = want;
                    n_ctl.op2 = want ? pbd_pkg::OP_SUB : pbd_pkg::OP_NONE;
                end
                default: begin
                    swap      = want;
                    n_ctl.op2 = want ? pbd_pkg::OP_NONE : pbd_pkg::OP_SUB;
                end
            endcase
        end
    end

    logic [63:0]   r_opa, r_opb;
    pbd_pkg::t_ctl r_ctl [7];
    logic [63:0]   r_pass [3];
    logic [63:0]   sum1, sum2, x2, b2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[6:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_opa    <= swap ? rb : lb;
            r_opb    <= swap ? {~lb[63], lb[62:0]} : {~rb[63], rb[62:0]};
            r_ctl[0] <= n_ctl;
            for (int i = 1; i < 7; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
            r_pass[0] <= x2;
            r_pass[1] <= r_pass[0];
            r_pass[2] <= r_pass[1];
        end
    end

    pbd_fadd u_diff (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_opa),
        .i_b   (r_opb),
        .o_sum (sum1)
    );

    assign x2 = r_ctl[3].use_abs ? {1'b0, sum1[62:0]} : sum1;
    assign b2 = (r_ctl[3].op2 == pbd_pkg::OP_SUB) ? {~r_eps[63], r_eps[62:0]} : r_eps;

    pbd_fadd u_eps (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (x2),
        .i_b   (b2),
        .o_sum (sum2)
    );

    logic [63:0] v, n_dist;
    logic        r_truth;
    logic [63:0] r_dist;

    always_comb begin
        v = (r_ctl[6].op2 == pbd_pkg::OP_NONE) ? r_pass[2] : sum2;
        if (r_ctl[6].neg) v = {~v[63], v[62:0]};
        case (r_ctl[6].kind)
            pbd_pkg::K_ZERO: n_dist = pbd_pkg::POS_ZERO;
            pbd_pkg::K_NEG1: n_dist = pbd_pkg::NEG_ONE;
            pbd_pkg::K_PEN:  n_dist = r_pen;
            pbd_pkg::K_EPS:  n_dist = pbd_pkg::canon(r_eps);
            default:         n_dist = pbd_pkg::canon(v);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_truth <= r_ctl[6].truth;
            r_dist  <= n_dist;
        end
    end

    assign o_out_valid     = r_vld[7];
    assign o_compare_truth = r_truth;
    assign o_distance_bits = r_dist;

endmodule

// ===== sim/predicate_branch_distance_tb.sv =====
// Testbench for predicate_branch_distance: random and directed compares checked
// against a behavioral double-precision predictor in a small scoreboard class.
// Depends on pbd_pkg and the predicate_branch_distance RTL.
module predicate_branch_distance_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        truth;
        logic [63:0] dist_bits;
    } t_outcome;

    class distance_scoreboard;
        logic [63:0] eps_bits;
        logic [63:0] pen_bits;
        logic        self_on;
        t_outcome    pending_q[$];
        int          errors;
        int          checked;

        function new();
            eps_bits = 64'd0;
            pen_bits = 64'd0;
            self_on  = 1'b1;
            errors   = 0;
            checked  = 0;
        endfunction

        function bit nan_b(logic [63:0] b);
            return (b[62:52] == 11'h7FF) && (b[51:0] != 0);
        endfunction

        function bit inf_b(logic [63:0] b);
            return (b[62:52] == 11'h7FF) && (b[51:0] == 0);
        endfunction

        function real mag(real x);
            logic [63:0] b;
            b = $realtobits(x);
            b[63] = 1'b0;
            return $bitstoreal(b);
        endfunction

        function logic [63:0] canon_bits(real x);
            logic [63:0] b;
            b = $realtobits(x);
            return nan_b(b) ? pbd_pkg::QNAN_BITS : b;
        endfunction

        function pbd_pkg::t_rel relation(logic [5:0] c);
            case (c)
                pbd_pkg::P_IEQ, pbd_pkg::P_OEQ, pbd_pkg::P_UEQ:
                    return pbd_pkg::REL_EQ;
                pbd_pkg::P_INE, pbd_pkg::P_ONE, pbd_pkg::P_UNE:
                    return pbd_pkg::REL_NE;
                pbd_pkg::P_IUGT, pbd_pkg::P_ISGT, pbd_pkg::P_OGT, pbd_pkg::P_UGT:
                    return pbd_pkg::REL_GT;
                pbd_pkg::P_IUGE, pbd_pkg::P_ISGE, pbd_pkg::P_OGE, pbd_pkg::P_UGE:
                    return pbd_pkg::REL_GE;
                pbd_pkg::P_IULT, pbd_pkg::P_ISLT, pbd_pkg::P_OLT, pbd_pkg::P_ULT:
                    return pbd_pkg::REL_LT;
                pbd_pkg::P_IULE, pbd_pkg::P_ISLE, pbd_pkg::P_OLE, pbd_pkg::P_ULE:
                    return pbd_pkg::REL_LE;
                default:
                    return pbd_pkg::REL_NONE;
            endcase
        endfunction

        function void note_input(logic [63:0] lb, logic [63:0] rb, logic [5:0] c, logic want);
            real l, r, e, d;
            bit nan, odd, raw, truth, fixed_code;
            pbd_pkg::t_rel rel;
            t_outcome o;
            l = $bitstoreal(lb);
            r = $bitstoreal(rb);
            e = $bitstoreal(eps_bits);
            nan = nan_b(lb) || nan_b(rb);
            odd = nan || inf_b(lb) || inf_b(rb);
            rel = relation(c);
            case (rel)
                pbd_pkg::REL_EQ: raw = (l == r);
                pbd_pkg::REL_NE: raw = (l != r);
                pbd_pkg::REL_GT: raw = (l > r);
                pbd_pkg::REL_GE: raw = (l >= r);
                pbd_pkg::REL_LT: raw = (l < r);
                pbd_pkg::REL_LE: raw = (l <= r);
                default:         raw = 0;
            endcase
            if (c == pbd_pkg::P_FALSE) truth = 0;
            else if (c == pbd_pkg::P_TRUE) truth = 1;
            else if (c == pbd_pkg::P_ORD) truth = !nan;
            else if (c == pbd_pkg::P_UNO) truth = nan;
            else if (rel == pbd_pkg::REL_NONE) truth = 0;
            else if (c >= pbd_pkg::P_IEQ) truth = raw;
            else if (c >= pbd_pkg::P_UEQ) truth = nan || raw;
            else truth = !nan && raw;
            fixed_code = (c == pbd_pkg::P_FALSE) || (c == pbd_pkg::P_TRUE)
                      || (c == pbd_pkg::P_ORD) || (c == pbd_pkg::P_UNO);
            if (truth != want) begin
                if ((odd && c != pbd_pkg::P_ORD && c != pbd_pkg::P_UNO)
                        || rel == pbd_pkg::REL_NONE) begin
                    if (c == pbd_pkg::P_FALSE && !want) o.dist_bits = pbd_pkg::POS_ZERO;
                    else if (c == pbd_pkg::P_TRUE && want) o.dist_bits = pbd_pkg::POS_ZERO;
                    else o.dist_bits = pen_bits;
                end else begin
                    case (rel)
                        pbd_pkg::REL_EQ: d = want ? mag(l - r) : e;
                        pbd_pkg::REL_NE: d = want ? e : mag(l - r);
                        pbd_pkg::REL_GT: d = want ? (r - l + e) : (l - r);
                        pbd_pkg::REL_GE: d = want ? (r - l) : (l - r + e);
                        pbd_pkg::REL_LT: d = want ? (l - r + e) : (r - l);
                        default:         d = want ? (l - r) : (r - l + e);
                    endcase
                    o.dist_bits = canon_bits(d);
                end
            end else if (self_on) begin
                o.dist_bits = pbd_pkg::POS_ZERO;
            end else if (fixed_code || odd || rel == pbd_pkg::REL_NONE) begin
                o.dist_bits = pbd_pkg::NEG_ONE;
            end else begin
                case (rel)
                    pbd_pkg::REL_EQ: d = want ? 0.0 : -(mag(l - r) - e);
                    pbd_pkg::REL_NE: d = want ? -(mag(l - r) - e) : 0.0;
                    pbd_pkg::REL_GT: d = want ? -(l - r - e) : -(r - l);
                    pbd_pkg::REL_GE: d = want ? -(l - r) : -(r - l - e);
                    pbd_pkg::REL_LT: d = want ? -(r - l - e) : -(l - r);
                    default:         d = want ? -(r - l) : -(l - r - e);
                endcase
                o.dist_bits = canon_bits(d);
            end
            o.truth = truth;
            pending_q.push_back(o);
        endfunction

        task report(string msg);
            if (errors < 40) $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic truth, logic [63:0] distance);
            t_outcome o;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result truth=%0b distance=%h", truth, distance));
            end else begin
                o = pending_q.pop_front();
                checked++;
                if (truth !== o.truth)
                    report($sformatf("truth %0b, want %0b", truth, o.truth));
                if (distance !== o.dist_bits)
                    report($sformatf("distance %h, want %h", distance, o.dist_bits));
            end
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_ready;
    logic [63:0] i_left_operand = 0;
    logic [63:0] i_right_operand = 0;
    logic [5:0]  i_predicate_code = 0;
    logic        i_wanted_outcome = 0;
    logic        o_out_valid;
    logic        i_out_ready = 0;
    logic        o_compare_truth;
    logic [63:0] o_distance_bits;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_index = 0;
    logic [63:0] i_cfg_wdata = 0;

    distance_scoreboard sb = new();
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cycles = 0;
    int sent = 0;
    localparam int CYCLE_LIMIT = 400000;

    logic [5:0] valid_codes[26] = '{pbd_pkg::P_FALSE, pbd_pkg::P_OEQ, pbd_pkg::P_OGT,
        pbd_pkg::P_OGE, pbd_pkg::P_OLT, pbd_pkg::P_OLE, pbd_pkg::P_ONE, pbd_pkg::P_ORD,
        pbd_pkg::P_UNO, pbd_pkg::P_UEQ, pbd_pkg::P_UGT, pbd_pkg::P_UGE, pbd_pkg::P_ULT,
        pbd_pkg::P_ULE, pbd_pkg::P_UNE, pbd_pkg::P_TRUE, pbd_pkg::P_IEQ, pbd_pkg::P_INE,
        pbd_pkg::P_IUGT, pbd_pkg::P_IUGE, pbd_pkg::P_IULT, pbd_pkg::P_IULE,
        pbd_pkg::P_ISGT, pbd_pkg::P_ISGE, pbd_pkg::P_ISLT, pbd_pkg::P_ISLE};

    predicate_branch_distance dut (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) sb.check_result(o_compare_truth, o_distance_bits);
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task send_compare(logic [63:0] lb, logic [63:0] rb, logic [5:0] c, logic want);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_left_operand   <= lb;
        i_right_operand  <= rb;
        i_predicate_code <= c;
        i_wanted_outcome <= want;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(lb, rb, c, want);
        sent++;
    endtask

    task wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task write_regs(logic [63:0] eps, logic [63:0] pen, logic self_m);
        i_cfg_we <= 1'b1; i_cfg_index <= pbd_pkg::CFG_EPS; i_cfg_wdata <= eps;
        @(posedge i_clk);
        i_cfg_index <= pbd_pkg::CFG_PENALTY; i_cfg_wdata <= pen;
        @(posedge i_clk);
        i_cfg_index <= pbd_pkg::CFG_SELF; i_cfg_wdata <= {63'd0, self_m};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.eps_bits = eps;
        sb.pen_bits = pen;
        sb.self_on  = self_m;
    endtask

    function logic [63:0] rand_double();
        logic [63:0] b;
        b = {$urandom, $urandom};
        case ($urandom_range(11))
            0: b = {b[63], 63'd0};
            1: b = {b[63], 11'h7FF, 52'd0};
            2: b = {b[63], 11'h7FF, b[51:1], 1'b1};
            3: b = {b[63], 11'h000, b[51:0]};
            4: b = {b[63], 11'h7FE, 52'hF_FFFF_FFFF_FFFF};
            5, 6: ;
            default: b[62:52] = 11'd1013 + 11'($urandom_range(20));
        endcase
        return b;
    endfunction

    task send_random();
        logic [63:0] lb, rb;
        logic [5:0] c;
        lb = rand_double();
        case ($urandom_range(9))
            0, 1, 2: rb = lb;
            3, 4:    rb = lb ^ 64'($urandom_range(255));
            default: rb = rand_double();
        endcase
        c = ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                     : valid_codes[$urandom_range(25)];
        send_compare(lb, rb, c, 1'($urandom_range(1)));
    endtask

    logic [63:0] eps_set[6] = '{64'h3FF0_0000_0000_0000, 64'h0000_0000_0000_0001,
        64'h7FF0_0000_0000_0000, 64'h7FF8_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF,
        64'h3E80_0000_0000_0000};
    logic [63:0] pen_set[6] = '{64'h4059_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h0000_0000_0000_0000, 64'h7FF0_0000_0000_0001, 64'h7FF0_0000_0000_0000,
        64'h3FF8_0000_0000_0000};

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every code once, cycling plain, equal, NaN and infinite operands, reset config
        for (int k = 0; k < 26; k++) begin
            case (k % 4)
                0: send_compare(64'h3FF0_0000_0000_0000, 64'h4000_0000_0000_0000,
                                valid_codes[k], k[2]);
                1: send_compare(64'hC000_0000_0000_0000, 64'hC000_0000_0000_0000,
                                valid_codes[k], k[3]);
                2: send_compare(64'h7FF8_0000_0000_0000, 64'h0, valid_codes[k], k[2]);
                default: send_compare(64'hFFF0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
                                      valid_codes[k], k[3]);
            endcase
        end
        send_compare(64'h0, 64'h8000_0000_0000_0000, 6'd63, 1'b1);
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            if (p == 5) write_regs({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
            else write_regs(eps_set[p], pen_set[p], p[0]);
            tx_idle_pct = (p < 2) ? 31 : (p < 4) ? 48 : 0;
            rx_idle_pct = (p < 2) ? 48 : (p < 4) ? 31 : 0;
            for (int n = 0; n < 150; n++) send_random();
            wait_drained();
        end

        $display("sent %0d compares, checked %0d results over 7 register settings",
                 sent, sb.checked);
        $display("both self and safety modes, special operands and unknown codes");
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
